// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file r250_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define R250_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle during reset.
`define R250_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define R250_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/r250_pkg.sv =====
package r250_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] limit;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        status;
   } rsp_type;

   localparam logic [1:0] MODE_RESEED  = 2'd0;
   localparam logic [1:0] MODE_RAW     = 2'd1;
   localparam logic [1:0] MODE_BOUNDED = 2'd2;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_ZERO_LIMIT = 1'b1;

   localparam logic [7:0] TABLE_LAST = 8'd249;
   localparam logic [7:0] TABLE_LAG  = 8'd103;

   localparam logic [31:0] LCG_MULT = 32'd16807;
   localparam logic [31:0] LCG_MOD  = 32'd2147483647;
   localparam logic [31:0] LCG_Q    = 32'd127773;
   localparam logic [31:0] LCG_R    = 32'd2836;
   // floor(2^48 / q); the quotient estimate is low by at most one
   localparam logic [31:0] LCG_RECIP = 32'((64'd1 << 48) / 64'd127773);

   localparam logic [31:0] WORD_ONES = 32'hffffffff;
   localparam logic [31:0] WORD_MSB  = 32'h80000000;

endpackage

// ===== sv/r250_random_generator.sv =====
// Channel   Direction  Payload                 Handshake
// req_      in         mode, limit             req_valid / req_ready
// rsp_      out        value, status           rsp_valid / rsp_ready
// csr_      in/out     seed_value (addr 0)     APB write, pready always high
//
// Raw draw: both table words are read into registers when the request is
// accepted; the DRAW state writes the XOR word back and loads the result.
// Each rejected bounded draw repeats the DRAW state. Reseed: two Park-Miller
// steps a word, each through ST_LCG_MUL, ST_LCG_QD, ST_LCG_FIX, ST_LCG_AB, ST_LCG_T.
// Limit zero and unused mode answer at the accept edge, or wait if the output is stalled.
// Reset (synchronous) starts an automatic reseed with seed 0; req_ready is low
// until that fill ends. No request is taken while a result waits in a
// stalled holding register; one result may sit in the output register.
module r250_random_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  r250_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output r250_pkg::rsp_type  rsp_payload,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW,
      ST_LCG_MUL,
      ST_LCG_QD,
      ST_LCG_FIX,
      ST_LCG_AB,
      ST_LCG_T,
      ST_HOLD
   } state_type;

   // lag table, one write port and two registered read ports
   logic [31:0] table_mem [0:249];
   logic [31:0] rd_a_ff, rd_b_ff;
   logic [7:0]  rd_addr_a, rd_addr_b;
   logic        mem_we;
   logic [7:0]  mem_waddr;
   logic [31:0] mem_wdata;

   // control
   state_type         state_ff, state_in;
   logic [7:0]        ptr_ff, ptr_in;      // word under the pointer
   logic [7:0]        lag_ff, lag_in;      // word 103 places ahead
   logic [7:0]        word_ff, word_in;    // fill index
   logic [2:0]        mod5_ff, mod5_in;    // word index mod 5
   logic [5:0]        diag_ff, diag_in;    // diagonal words done
   logic              half_ff, half_in;    // second LCG draw of a word
   logic              report_ff, report_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       seed_ff;
   logic [31:0]       lcg_ff, lcg_in;

   // datapath
   logic              bounded_ff, bounded_in;
   logic [31:0]       mask_ff, mask_in;
   logic [31:0]       limit_ff, limit_in;
   logic [15:0]       q0_ff, q0_in;
   logic [31:0]       qd_ff, qd_in;
   logic [15:0]       q_ff, q_in;
   logic [16:0]       r_ff, r_in;
   logic [31:0]       a_ff, a_in;
   logic [31:0]       b_ff, b_in;
   logic [31:0]       first_ff, first_in;
   r250_pkg::rsp_type hold_ff, hold_in;
   r250_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic              out_free;
   logic              accept;
   logic              push_en;
   r250_pkg::rsp_type push_data;
   logic [7:0]        ptr_next, lag_next;
   logic [31:0]       draw_word, draw_masked;
   logic [63:0]       recip_prod;
   logic [31:0]       rem0, lcg_t, fill_word;
   logic [31:0]       limit_smear;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = seed_ff;

   assign ptr_next = (ptr_ff == r250_pkg::TABLE_LAST) ? 8'd0 : ptr_ff + 8'd1;
   assign lag_next = (lag_ff == r250_pkg::TABLE_LAST) ? 8'd0 : lag_ff + 8'd1;

   // while draws repeat, fetch the following pair during the write-back;
   // neither address can equal the word being written
   assign rd_addr_a = (state_ff == ST_DRAW) ? ptr_next : ptr_ff;
   assign rd_addr_b = (state_ff == ST_DRAW) ? lag_next : lag_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= table_mem[rd_addr_a];
      rd_b_ff <= table_mem[rd_addr_b];
   end

   // seed register; any address in range is register 0
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         seed_ff <= csr_pwdata;
      end
   end

   // smallest all-ones mask covering the limit
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         limit_smear[i] = |(req_payload.limit >> i);
      end
   end

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      lag_in         = lag_ff;
      word_in        = word_ff;
      mod5_in        = mod5_ff;
      diag_in        = diag_ff;
      half_in        = half_ff;
      report_in      = report_ff;
      lcg_in         = lcg_ff;
      bounded_in     = bounded_ff;
      mask_in        = mask_ff;
      limit_in       = limit_ff;
      q0_in          = q0_ff;
      qd_in          = qd_ff;
      q_in           = q_ff;
      r_in           = r_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      first_in       = first_ff;
      hold_in        = hold_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      mem_we         = 1'b0;
      mem_waddr      = ptr_ff;
      mem_wdata      = '0;
      push_en        = 1'b0;
      push_data      = '0;

      draw_word   = rd_a_ff ^ rd_b_ff;
      draw_masked = draw_word & mask_ff;
      recip_prod  = lcg_ff * r250_pkg::LCG_RECIP;
      rem0        = lcg_ff - qd_ff;
      lcg_t       = a_ff - b_ff;
      if (lcg_t[31]) begin
         lcg_t = lcg_t + r250_pkg::LCG_MOD;
      end
      fill_word = first_ff ^ (lcg_t << 8);
      if (mod5_ff == 3'd3 && !diag_ff[5]) begin
         fill_word = (fill_word & (r250_pkg::WORD_ONES >> diag_ff[4:0]))
                   | (r250_pkg::WORD_MSB >> diag_ff[4:0]);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.mode)
                  r250_pkg::MODE_RESEED: begin
                     lcg_in    = seed_ff;
                     ptr_in    = 8'd0;
                     lag_in    = r250_pkg::TABLE_LAG;
                     word_in   = 8'd0;
                     mod5_in   = 3'd0;
                     diag_in   = 6'd0;
                     half_in   = 1'b0;
                     report_in = 1'b1;
                     state_in  = ST_LCG_MUL;
                  end
                  r250_pkg::MODE_RAW: begin
                     bounded_in = 1'b0;
                     mask_in    = r250_pkg::WORD_ONES;
                     state_in   = ST_DRAW;
                  end
                  r250_pkg::MODE_BOUNDED: begin
                     if (req_payload.limit == 32'd0) begin
                        push_en          = 1'b1;
                        push_data.status = r250_pkg::STATUS_ZERO_LIMIT;
                     end else begin
                        bounded_in = 1'b1;
                        mask_in    = limit_smear | 32'd1;
                        limit_in   = req_payload.limit;
                        state_in   = ST_DRAW;
                     end
                  end
                  default: begin
                     push_en          = 1'b1;
                     push_data.status = r250_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_DRAW: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = draw_word;
            ptr_in    = ptr_next;
            lag_in    = lag_next;
            if (!(bounded_ff && draw_masked >= limit_ff)) begin
               push_en          = 1'b1;
               push_data.value  = draw_masked;
               push_data.status = r250_pkg::STATUS_OK;
               state_in         = ST_IDLE;
            end
         end
         ST_LCG_MUL: begin
            q0_in    = recip_prod[63:48];
            state_in = ST_LCG_QD;
         end
         ST_LCG_QD: begin
            qd_in    = {16'd0, q0_ff} * r250_pkg::LCG_Q;
            state_in = ST_LCG_FIX;
         end
         ST_LCG_FIX: begin
            if (rem0 >= r250_pkg::LCG_Q) begin
               q_in = q0_ff + 16'd1;
               r_in = 17'(rem0 - r250_pkg::LCG_Q);
            end else begin
               q_in = q0_ff;
               r_in = rem0[16:0];
            end
            state_in = ST_LCG_AB;
         end
         ST_LCG_AB: begin
            a_in     = {15'd0, r_ff} * r250_pkg::LCG_MULT;
            b_in     = {16'd0, q_ff} * r250_pkg::LCG_R;
            state_in = ST_LCG_T;
         end
         ST_LCG_T: begin
            lcg_in = lcg_t;
            if (!half_ff) begin
               first_in = lcg_t;
               half_in  = 1'b1;
               state_in = ST_LCG_MUL;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = word_ff;
               mem_wdata = fill_word;
               half_in   = 1'b0;
               mod5_in   = (mod5_ff == 3'd4) ? 3'd0 : mod5_ff + 3'd1;
               if (mod5_ff == 3'd3 && !diag_ff[5]) begin
                  diag_in = diag_ff + 6'd1;
               end
               if (word_ff == r250_pkg::TABLE_LAST) begin
                  state_in  = ST_IDLE;
                  report_in = 1'b0;
                  if (report_ff) begin
                     push_en          = 1'b1;
                     push_data.status = r250_pkg::STATUS_OK;
                  end
               end else begin
                  word_in  = word_ff + 8'd1;
                  state_in = ST_LCG_MUL;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = hold_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a finished result goes out now, or waits while the output is stalled
      if (push_en) begin
         if (out_free) begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = push_data;
         end else begin
            hold_in  = push_data;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      bounded_ff     <= bounded_in;
      mask_ff        <= mask_in;
      limit_ff       <= limit_in;
      q0_ff          <= q0_in;
      qd_ff          <= qd_in;
      q_ff           <= q_in;
      r_ff           <= r_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      first_ff       <= first_in;
      hold_ff        <= hold_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         // automatic reseed with seed 0, no result reported
         state_ff     <= ST_LCG_MUL;
         ptr_ff       <= 8'd0;
         lag_ff       <= r250_pkg::TABLE_LAG;
         word_ff      <= 8'd0;
         mod5_ff      <= 3'd0;
         diag_ff      <= 6'd0;
         half_ff      <= 1'b0;
         report_ff    <= 1'b0;
         lcg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         lag_ff       <= lag_in;
         word_ff      <= word_in;
         mod5_ff      <= mod5_in;
         diag_ff      <= diag_in;
         half_ff      <= half_in;
         report_ff    <= report_in;
         lcg_ff       <= lcg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/r250_chk.sv =====
`include "assert_macros.svh"

module r250_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input r250_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input r250_pkg::rsp_type rsp_payload
);

   logic draw_taken;

   assign draw_taken = req_valid && req_ready
                    && (req_payload.mode == r250_pkg::MODE_RAW
                        || (req_payload.mode == r250_pkg::MODE_BOUNDED
                            && req_payload.limit != 32'd0));

   `R250_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled response changed")

   `R250_ASSERT_NOW(a_zero_limit_value, rsp_valid && rsp_payload.status, rsp_payload.value == 32'd0, "flagged response carries a value")

   `R250_ASSERT_NEXT(a_draw_busy, draw_taken, !req_ready, "request taken during a table draw")

   `R250_ASSERT_ALWAYS(a_reset_seed, reset, !req_ready && !rsp_valid, "block not seeding after reset")

endmodule

bind r250_random_generator r250_chk u_r250_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== verif/tb_r250_random_generator.sv =====
module tb_r250_random_generator;

   localparam int TABLE_WORDS = int'(r250_pkg::TABLE_LAST) + 1;
   localparam int LAG_WRAP    = TABLE_WORDS - int'(r250_pkg::TABLE_LAG);
   localparam int DIAG_WORDS  = 32;
   // mode 3 has no function; the block answers zero with status ok
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] SEED_ADDR   = 2'd0;
   localparam int ITEMS_PER_PHASE     = 617;

   // Shadow copy of the generator: lag table, pointer, LCG and seed register.
   // Every accepted request is run through it at once and the response it
   // must produce is queued; the block answers strictly in order.
   class r250_scoreboard;
      logic [31:0]       lag_words [TABLE_WORDS];
      int unsigned       word_ptr;
      logic [31:0]       lcg_word;
      logic [31:0]       seed_word;
      r250_pkg::rsp_type expected_rsps [$];
      int unsigned       mismatch_count;

      function new();
         seed_word      = '0;
         word_ptr       = 0;
         lcg_word       = '0;
         mismatch_count = 0;
         reseed_table();
      endfunction

      function void set_seed(logic [31:0] seed);
         seed_word = seed;
      endfunction

      // Park-Miller step, Schrage form, wrapping 32-bit arithmetic
      function logic [31:0] lcg_step();
         logic [31:0] t;
         t = r250_pkg::LCG_MULT * (lcg_word % r250_pkg::LCG_Q)
           - r250_pkg::LCG_R * (lcg_word / r250_pkg::LCG_Q);
         if (t[31])
            t = t + r250_pkg::LCG_MOD;
         lcg_word = t;
         return t;
      endfunction

      function void reseed_table();
         logic [31:0] first;
         logic [31:0] second;
         logic [31:0] keep;
         logic [31:0] top;
         int k;
         lcg_word = seed_word;
         word_ptr = 0;
         for (int j = 0; j < TABLE_WORDS; j++) begin
            first        = lcg_step();
            second       = lcg_step();
            lag_words[j] = first ^ (second << 8);
         end
         // diagonal: word 5j+3 gets bit 31-j set, everything above cleared
         keep = r250_pkg::WORD_ONES;
         top  = r250_pkg::WORD_MSB;
         for (int j = 0; j < DIAG_WORDS; j++) begin
            k            = 5 * j + 3;
            lag_words[k] = (lag_words[k] & keep) | top;
            keep         = keep >> 1;
            top          = top >> 1;
         end
      endfunction

      function logic [31:0] next_word();
         int unsigned partner;
         logic [31:0] w;
         partner = (word_ptr >= LAG_WRAP) ? word_ptr - LAG_WRAP
                                          : word_ptr + r250_pkg::TABLE_LAG;
         w = lag_words[word_ptr] ^ lag_words[partner];
         lag_words[word_ptr] = w;
         word_ptr = (word_ptr >= TABLE_WORDS - 1) ? 0 : word_ptr + 1;
         return w;
      endfunction

      function void note_request(r250_pkg::req_type item);
         r250_pkg::rsp_type want;
         logic [31:0]       mask;
         logic [31:0]       draw;
         want.value  = '0;
         want.status = r250_pkg::STATUS_OK;
         case (item.mode)
            r250_pkg::MODE_RESEED: reseed_table();
            r250_pkg::MODE_RAW: want.value = next_word();
            r250_pkg::MODE_BOUNDED: begin
               if (item.limit == '0) begin
                  want.status = r250_pkg::STATUS_ZERO_LIMIT;
               end else begin
                  mask = 32'd1;
                  while (item.limit > mask)
                     mask = {mask[30:0], 1'b1};
                  // rejected draws still step the table
                  do
                     draw = next_word() & mask;
                  while (draw >= item.limit);
                  want.value = draw;
               end
            end
            default: ;
         endcase
         expected_rsps.push_back(want);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatch_count++;
         $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $time);
      endtask

      task check_result(r250_pkg::rsp_type got);
         r250_pkg::rsp_type want;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no request outstanding", got.value, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.value !== want.value)
               report_mismatch("value", got.value, want.value);
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
         end
      endtask

      function int unsigned waiting();
         return expected_rsps.size();
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   r250_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   r250_pkg::rsp_type rsp_payload;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [1:0]        csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // idle odds in percent per cycle, changed per phase
   int unsigned send_idle_pct = 9;
   int unsigned rsp_stall_pct = 78;

   r250_scoreboard sb = new();

   r250_random_generator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Response side: check on each handshake, then pick ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_payload);
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic r250_pkg::req_type request_of(logic [1:0] mode, logic [31:0] limit);
      r250_pkg::req_type item;
      item.mode  = mode;
      item.limit = limit;
      return item;
   endfunction

   // Mostly draws with a spread of limits; reseeds rare enough that the
   // pointer can wrap past word 249 between them; some zero limits and mode 3.
   function automatic r250_pkg::req_type random_request();
      r250_pkg::req_type item;
      int unsigned       pick;
      pick       = $urandom_range(999);
      item.limit = $urandom;
      if (pick < 7) begin
         item.mode = r250_pkg::MODE_RESEED;
      end else if (pick < 420) begin
         item.mode = r250_pkg::MODE_RAW;
      end else if (pick < 950) begin
         item.mode = r250_pkg::MODE_BOUNDED;
         case ($urandom_range(3))
            0: item.limit = $urandom_range(20, 1);
            1: item.limit = $urandom >> $urandom_range(31);
            // around a power of two, where the mask steps
            2: item.limit = (32'd1 << $urandom_range(31)) + 32'($urandom_range(2)) - 32'd1;
            default: item.limit = $urandom;
         endcase
         if (item.limit == '0)
            item.limit = 32'd1;
      end else if (pick < 970) begin
         item.mode  = r250_pkg::MODE_BOUNDED;
         item.limit = '0;
      end else begin
         item.mode = MODE_UNUSED;
      end
      return item;
   endfunction

   // Hold the request until taken; valid stays up unless an idle gap follows.
   task automatic send_request(input r250_pkg::req_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
   endtask

   // Seed writes only with nothing in flight: drain, short pause, APB write.
   task automatic program_seed(input logic [31:0] seed);
      drain_requests();
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SEED_ADDR;
      csr_pwdata  <= seed;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_seed(seed);
   endtask

   initial begin
      logic [31:0] seed;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: table from the automatic seed-zero fill first. Ready stays
      // low during that fill, so the first request simply waits it out.
      send_request(request_of(r250_pkg::MODE_RAW, '0));
      send_request(request_of(r250_pkg::MODE_RAW, r250_pkg::WORD_ONES));
      send_request(request_of(r250_pkg::MODE_BOUNDED, '0));        // zero limit
      send_request(request_of(MODE_UNUSED, r250_pkg::WORD_ONES));  // unused mode
      send_request(request_of(r250_pkg::MODE_BOUNDED, 32'd1));     // only 0 passes
      send_request(request_of(r250_pkg::MODE_BOUNDED, 32'd2));
      send_request(request_of(r250_pkg::MODE_BOUNDED, 32'd3));
      send_request(request_of(r250_pkg::MODE_BOUNDED, 32'h7fffffff));
      // full mask from here up
      send_request(request_of(r250_pkg::MODE_BOUNDED, r250_pkg::WORD_MSB));
      send_request(request_of(r250_pkg::MODE_BOUNDED, 32'h80000001));
      send_request(request_of(r250_pkg::MODE_BOUNDED, r250_pkg::WORD_ONES));
      send_request(request_of(r250_pkg::MODE_RAW, 32'haaaaaaaa));

      // seed equal to the modulus: LCG sticks at zero, diagonal bits only
      program_seed(32'h7fffffff);
      send_request(request_of(r250_pkg::MODE_RESEED, 32'h55555555));
      send_request(request_of(r250_pkg::MODE_RAW, '0));
      send_request(request_of(r250_pkg::MODE_BOUNDED, 32'd5));
      // most negative seed
      program_seed(r250_pkg::WORD_MSB);
      send_request(request_of(r250_pkg::MODE_RESEED, '0));
      send_request(request_of(r250_pkg::MODE_RAW, '0));
      send_request(request_of(r250_pkg::MODE_BOUNDED, 32'h55555555));
      program_seed(r250_pkg::WORD_ONES);
      send_request(request_of(r250_pkg::MODE_RESEED, r250_pkg::WORD_ONES));
      send_request(request_of(r250_pkg::MODE_RAW, '0));
      // explicit reseed with seed zero
      program_seed('0);
      send_request(request_of(r250_pkg::MODE_RESEED, '0));
      send_request(request_of(r250_pkg::MODE_RAW, '0));

      // Random phases: slow receiver, then slow sender, then full rate.
      for (int ph = 0; ph < 3; ph++) begin
         seed = (ph == 0) ? 32'd1 : $urandom;
         program_seed(seed);
         send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 78 : 0;
         rsp_stall_pct = (ph == 0) ? 78 : (ph == 1) ? 9 : 0;
         send_request(request_of(r250_pkg::MODE_RESEED, $urandom));
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(random_request());
      end

      drain_requests();
      repeat (8) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.waiting() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run, reseeds included.
   initial begin
      #16_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/r250_pkg.sv
sv/r250_random_generator.sv
sv/r250_chk.sv
verif/tb_r250_random_generator.sv
